>>> src/scan_code_set1_to_ascii_assert.svh
// ----------------------------------------------------------------------------
// scan_code_set1_to_ascii_assert.svh
// Assertion macros shared by the decoder checks.
// ----------------------------------------------------------------------------
`ifndef SCAN_CODE_SET1_TO_ASCII_ASSERT_SVH
`define SCAN_CODE_SET1_TO_ASCII_ASSERT_SVH

// Clocked property with reset disable.
`define SCS1A_ASSERT(lbl, clk_s, rst_s, prop, msg) \
    lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (prop)) else $error(msg);

// Overlapped implication.
`define SCS1A_ASSERT_IMPLY(lbl, clk_s, rst_s, pre, post, msg) \
    `SCS1A_ASSERT(lbl, clk_s, rst_s, (pre) |-> (post), msg)

// Next-cycle implication.
`define SCS1A_ASSERT_NEXT(lbl, clk_s, rst_s, pre, post, msg) \
    `SCS1A_ASSERT(lbl, clk_s, rst_s, (pre) |=> (post), msg)

`endif

>>> src/scs1a_pkg.sv
// ----------------------------------------------------------------------------
// scs1a_pkg
// Types, key codes and translation tables for the scan code decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package scs1a_pkg;

    localparam int KEY_COUNT = 128;

    localparam logic [7:0] CAPS_KEY    = 8'h3a;
    localparam logic [7:0] PREFIX_BYTE = 8'he0;
    localparam logic [6:0] K_LSHIFT    = 7'h2a;
    localparam logic [6:0] K_RSHIFT    = 7'h36;
    localparam logic [6:0] K_CTRL      = 7'h1d;
    localparam logic [6:0] K_ALT       = 7'h38;
    localparam logic [6:0] CASE_STEP   = 7'd32;
    localparam logic [7:0] LED_CMD     = 8'hed;

    typedef struct packed {
        logic [KEY_COUNT-1:0] key_down;
        logic [KEY_COUNT-1:0] ext_down;
        logic                 ext_pending;
        logic                 caps_on;
    } key_state_t;

    typedef struct packed {
        logic       char_valid;
        logic [6:0] char_code;
        logic       led_update;
        logic [2:0] led_bits;
        logic       shift_on;
        logic       ctrl_on;
        logic       alt_on;
    } result_t;

    function automatic logic [6:0] common_char(input logic [6:0] k);
        logic [6:0] c;
        case (k)
            7'h0e: c = 7'h08;
            7'h0f: c = 7'h09;
            7'h1c: c = 7'h0a;
            7'h37: c = 7'h2a;
            7'h39: c = 7'h20;
            7'h47: c = 7'h37;
            7'h48: c = 7'h38;
            7'h49: c = 7'h39;
            7'h4a: c = 7'h2d;
            7'h4b: c = 7'h34;
            7'h4c: c = 7'h35;
            7'h4d: c = 7'h36;
            7'h4e: c = 7'h2b;
            7'h4f: c = 7'h31;
            7'h50: c = 7'h32;
            7'h51: c = 7'h33;
            7'h52: c = 7'h30;
            7'h53: c = 7'h2e;
            default: c = 7'h00;
        endcase
        return c;
    endfunction

    function automatic logic [6:0] plain_char(input logic [6:0] k);
        logic [6:0] c;
        case (k)
            7'h02: c = 7'h31;
            7'h03: c = 7'h32;
            7'h04: c = 7'h33;
            7'h05: c = 7'h34;
            7'h06: c = 7'h35;
            7'h07: c = 7'h36;
            7'h08: c = 7'h37;
            7'h09: c = 7'h38;
            7'h0a: c = 7'h39;
            7'h0b: c = 7'h30;
            7'h0c: c = 7'h2d;
            7'h0d: c = 7'h3d;
            7'h10: c = 7'h71;
            7'h11: c = 7'h77;
            7'h12: c = 7'h65;
            7'h13: c = 7'h72;
            7'h14: c = 7'h74;
            7'h15: c = 7'h79;
            7'h16: c = 7'h75;
            7'h17: c = 7'h69;
            7'h18: c = 7'h6f;
            7'h19: c = 7'h70;
            7'h1a: c = 7'h5b;
            7'h1b: c = 7'h5d;
            7'h1e: c = 7'h61;
            7'h1f: c = 7'h73;
            7'h20: c = 7'h64;
            7'h21: c = 7'h66;
            7'h22: c = 7'h67;
            7'h23: c = 7'h68;
            7'h24: c = 7'h6a;
            7'h25: c = 7'h6b;
            7'h26: c = 7'h6c;
            7'h27: c = 7'h3b;
            7'h28: c = 7'h27;
            7'h2b: c = 7'h5c;
            7'h2c: c = 7'h7a;
            7'h2d: c = 7'h78;
            7'h2e: c = 7'h63;
            7'h2f: c = 7'h76;
            7'h30: c = 7'h62;
            7'h31: c = 7'h6e;
            7'h32: c = 7'h6d;
            7'h33: c = 7'h2c;
            7'h34: c = 7'h2e;
            7'h35: c = 7'h2f;
            default: c = common_char(k);
        endcase
        return c;
    endfunction

    function automatic logic [6:0] shift_char(input logic [6:0] k);
        logic [6:0] c;
        case (k)
            7'h02: c = 7'h21;
            7'h03: c = 7'h40;
            7'h04: c = 7'h23;
            7'h05: c = 7'h24;
            7'h06: c = 7'h25;
            7'h07: c = 7'h5e;
            7'h08: c = 7'h26;
            7'h09: c = 7'h2a;
            7'h0a: c = 7'h28;
            7'h0b: c = 7'h29;
            7'h0c: c = 7'h5f;
            7'h0d: c = 7'h2b;
            7'h10: c = 7'h51;
            7'h11: c = 7'h57;
            7'h12: c = 7'h45;
            7'h13: c = 7'h52;
            7'h14: c = 7'h54;
            7'h15: c = 7'h59;
            7'h16: c = 7'h55;
            7'h17: c = 7'h49;
            7'h18: c = 7'h4f;
            7'h19: c = 7'h50;
            7'h1a: c = 7'h7b;
            7'h1b: c = 7'h7d;
            7'h1e: c = 7'h41;
            7'h1f: c = 7'h53;
            7'h20: c = 7'h44;
            7'h21: c = 7'h46;
            7'h22: c = 7'h47;
            7'h23: c = 7'h48;
            7'h24: c = 7'h4a;
            7'h25: c = 7'h4b;
            7'h26: c = 7'h4c;
            7'h27: c = 7'h3a;
            7'h28: c = 7'h22;
            7'h2b: c = 7'h7c;
            7'h2c: c = 7'h5a;
            7'h2d: c = 7'h58;
            7'h2e: c = 7'h43;
            7'h2f: c = 7'h56;
            7'h30: c = 7'h42;
            7'h31: c = 7'h4e;
            7'h32: c = 7'h4d;
            7'h33: c = 7'h3c;
            7'h34: c = 7'h3e;
            7'h35: c = 7'h3f;
            default: c = common_char(k);
        endcase
        return c;
    endfunction

    function automatic logic [6:0] swap_case(input logic [6:0] c);
        logic [6:0] r;
        r = c;
        if (c >= 7'h61 && c <= 7'h7a) begin
            r = c - CASE_STEP;
        end
        else if (c >= 7'h41 && c <= 7'h5a) begin
            r = c + CASE_STEP;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

>>> src/scan_code_set1_to_ascii.sv
// Each accepted scan word passes the input register, then the result register.
// Throughput: one word per cycle unless a result stall holds the words; key state
// updates as a word enters the result register; the next word sees it on the following cycle.
// Reset: asynchronous, active low; clears both pressed maps, the prefix and
// caps lock flags, and both valid flags.
// ----------------------------------------------------------------------------
// scan_code_set1_to_ascii
// Scan code set 1 decoder with input and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module scan_code_set1_to_ascii
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       scan_valid,
    output logic            scan_stall,
    input  wire logic [7:0] scan_byte,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic            char_valid,
    output logic [6:0]      char_code,
    output logic            led_update,
    output logic [2:0]      led_bits,
    output logic            shift_on,
    output logic            ctrl_on,
    output logic            alt_on
);
    import scs1a_pkg::*;

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       out_valid_reg;
    result_t    out_reg;

    logic       out_free;
    logic       advance;
    key_state_t cur_state;
    key_state_t next_state;
    result_t    res;

    assign out_free   = !out_valid_reg || !result_stall;
    assign advance    = in_valid_reg && out_free;
    assign scan_stall = in_valid_reg && !out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else begin
            if (!scan_stall) begin
                in_valid_reg <= scan_valid;
            end
            if (out_free) begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_valid && !scan_stall) begin
            in_byte_reg <= scan_byte;
        end
        if (advance) begin
            out_reg <= res;
        end
    end

    scs1a_key_state u_state
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .update     (advance),
        .state_next (next_state),
        .state      (cur_state)
    );

    scs1a_decode u_decode
    (
        .scan_byte (in_byte_reg),
        .cur       (cur_state),
        .nxt       (next_state),
        .res       (res)
    );

    assign result_valid = out_valid_reg;
    assign char_valid   = out_reg.char_valid;
    assign char_code    = out_reg.char_code;
    assign led_update   = out_reg.led_update;
    assign led_bits     = out_reg.led_bits;
    assign shift_on     = out_reg.shift_on;
    assign ctrl_on      = out_reg.ctrl_on;
    assign alt_on       = out_reg.alt_on;

endmodule

`default_nettype wire

>>> src/scs1a_decode.sv
// ----------------------------------------------------------------------------
// scs1a_decode
// Next key state and result for one scan byte.
// ----------------------------------------------------------------------------
`default_nettype none

module scs1a_decode
(
    input  wire logic [7:0]             scan_byte,
    input  wire scs1a_pkg::key_state_t  cur,
    output scs1a_pkg::key_state_t       nxt,
    output scs1a_pkg::result_t          res
);
    import scs1a_pkg::*;

    logic [6:0] k;
    logic [6:0] ch;
    logic       led;
    logic       shift_held;

    assign k = scan_byte[6:0];

    always_comb
    begin
        nxt        = cur;
        ch         = 7'h00;
        led        = 1'b0;
        shift_held = 1'b0;
        if (!scan_byte[7]) begin
            if (cur.ext_pending) begin
                nxt.ext_down[k]  = 1'b1;
                nxt.ext_pending  = 1'b0;
            end
            else if (scan_byte == CAPS_KEY) begin
                nxt.caps_on = !cur.caps_on;
                led         = 1'b1;
            end
            else begin
                nxt.key_down[k] = 1'b1;
                shift_held = nxt.key_down[K_LSHIFT] | nxt.key_down[K_RSHIFT];
                ch = shift_held ? shift_char(k) : plain_char(k);
                if (cur.caps_on) begin
                    ch = swap_case(ch);
                end
            end
        end
        else if (scan_byte == PREFIX_BYTE) begin
            nxt.ext_pending = 1'b1;
        end
        else if (cur.ext_pending) begin
            nxt.ext_down[k] = 1'b0;
            nxt.ext_pending = 1'b0;
        end
        else begin
            nxt.key_down[k] = 1'b0;
        end
    end

    always_comb
    begin
        res.char_valid = (ch != 7'h00);
        res.char_code  = ch;
        res.led_update = led;
        res.led_bits   = {nxt.caps_on, 2'b00};
        res.shift_on   = nxt.key_down[K_LSHIFT] | nxt.key_down[K_RSHIFT];
        res.ctrl_on    = nxt.key_down[K_CTRL] | nxt.ext_down[K_CTRL];
        res.alt_on     = nxt.key_down[K_ALT] | nxt.ext_down[K_ALT];
    end

endmodule

`default_nettype wire

>>> src/scs1a_key_state.sv
// ----------------------------------------------------------------------------
// scs1a_key_state
// Pressed maps, prefix flag and caps lock flag.
// ----------------------------------------------------------------------------
`default_nettype none

module scs1a_key_state
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   update,
    input  wire scs1a_pkg::key_state_t  state_next,
    output scs1a_pkg::key_state_t       state
);
    import scs1a_pkg::*;

    key_state_t state_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= '0;
        end
        else if (update) begin
            state_reg <= state_next;
        end
    end

    assign state = state_reg;

endmodule

`default_nettype wire

>>> src/scs1a_checker.sv
// ----------------------------------------------------------------------------
// scs1a_checker
// Port-level checks on the decoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "scan_code_set1_to_ascii_assert.svh"

module scs1a_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       scan_valid,
    input wire logic       scan_stall,
    input wire logic [7:0] scan_byte,
    input wire logic       result_valid,
    input wire logic       result_stall,
    input wire logic       char_valid,
    input wire logic [6:0] char_code,
    input wire logic       led_update,
    input wire logic [2:0] led_bits,
    input wire logic       shift_on,
    input wire logic       ctrl_on,
    input wire logic       alt_on
);

    `SCS1A_ASSERT_IMPLY(a_char_nonzero, clk, rst_n, result_valid,
        char_valid == (char_code != 7'h00), "char_valid disagrees with char_code")
    `SCS1A_ASSERT_IMPLY(a_led_no_char, clk, rst_n, result_valid && led_update,
        !char_valid, "caps toggle produced a character")
    `SCS1A_ASSERT_IMPLY(a_led_fixed, clk, rst_n, result_valid,
        led_bits[1:0] == 2'b00, "scroll or num LED bit set")
    `SCS1A_ASSERT_NEXT(a_hold, clk, rst_n, result_valid && result_stall,
        result_valid && $stable({char_valid, char_code, led_update, led_bits,
        shift_on, ctrl_on, alt_on}), "stalled result word changed")
    `SCS1A_ASSERT_NEXT(a_scan_hold, clk, rst_n, scan_valid && scan_stall,
        scan_valid && $stable(scan_byte), "stalled scan word changed")

endmodule

bind scan_code_set1_to_ascii scs1a_checker u_scs1a_checker (.*);

`default_nettype wire

>>> dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Testbench for the scan code set 1 decoder. A short table of directed words is
// followed by random key sequences; each result word is compared against a pinned
// word or a local decode, under random idling on both sides for the first two thirds.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

    import scs1a_pkg::*;

    localparam int RANDOM_WORDS = 850;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 10;
    localparam byte NO_CHAR     = 8'h7e;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       scan_valid   = 1'b0;
    logic [7:0] scan_byte    = 8'h00;
    logic       result_stall = 1'b0;
    wire        scan_stall;
    wire        result_valid;
    wire        char_valid;
    wire  [6:0] char_code;
    wire        led_update;
    wire  [2:0] led_bits;
    wire        shift_on;
    wire        ctrl_on;
    wire        alt_on;

    logic [7:0] scan_words[$];
    bit         pinned[$];
    result_t    pinned_want[$];
    result_t    expected_words[$];

    bit [KEY_COUNT-1:0] held_keys;
    bit [KEY_COUNT-1:0] held_ext_keys;
    bit                 prefix_seen;
    bit                 caps_lock;

    string plain_keys;
    string shift_keys;

    int words_sent;
    int idle_cycles;
    int errors;

    scan_code_set1_to_ascii DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .scan_valid   (scan_valid),
        .scan_stall   (scan_stall),
        .scan_byte    (scan_byte),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .char_valid   (char_valid),
        .char_code    (char_code),
        .led_update   (led_update),
        .led_bits     (led_bits),
        .shift_on     (shift_on),
        .ctrl_on      (ctrl_on),
        .alt_on       (alt_on)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic logic [6:0] key_char(input logic [6:0] k, input bit shifted);
        byte c;
        c = 8'h00;
        if (k < 7'd84)
        begin
            c = shifted ? shift_keys[k] : plain_keys[k];
        end
        if (c == NO_CHAR)
        begin
            c = 8'h00;
        end
        return c[6:0];
    endfunction

    function automatic result_t decode_word(input logic [7:0] b);
        result_t    r;
        logic [6:0] k;
        logic [6:0] c;
        r = '0;
        k = b[6:0];
        c = 7'h00;
        if (!b[7])
        begin
            if (prefix_seen)
            begin
                held_ext_keys[k] = 1'b1;
                prefix_seen = 1'b0;
            end
            else if (b == CAPS_KEY)
            begin
                caps_lock = !caps_lock;
                r.led_update = 1'b1;
            end
            else
            begin
                held_keys[k] = 1'b1;
                c = key_char(k, held_keys[K_LSHIFT] || held_keys[K_RSHIFT]);
                if (caps_lock && c >= 7'h61 && c <= 7'h7a)
                begin
                    c = c - 7'd32;
                end
                else if (caps_lock && c >= 7'h41 && c <= 7'h5a)
                begin
                    c = c + 7'd32;
                end
            end
        end
        else if (b == PREFIX_BYTE)
        begin
            prefix_seen = 1'b1;
        end
        else if (prefix_seen)
        begin
            held_ext_keys[k] = 1'b0;
            prefix_seen = 1'b0;
        end
        else
        begin
            held_keys[k] = 1'b0;
        end
        r.char_valid = (c != 7'h00);
        r.char_code  = c;
        r.led_bits   = {caps_lock, 2'b00};
        r.shift_on   = held_keys[K_LSHIFT] || held_keys[K_RSHIFT];
        r.ctrl_on    = held_keys[K_CTRL] || held_ext_keys[K_CTRL];
        r.alt_on     = held_keys[K_ALT] || held_ext_keys[K_ALT];
        return r;
    endfunction

    task automatic add_row(input logic [7:0] b, input bit fixed, input result_t want);
        scan_words.push_back(b);
        pinned.push_back(fixed);
        pinned_want.push_back(want);
    endtask

    task automatic add_random_sequence();
        int         kind;
        logic [7:0] k;
        logic [7:0] mod;
        logic [7:0] e;
        kind = $urandom_range(0, 99);
        k = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 127))
                                        : 8'($urandom_range(1, 8'h58));
        if (kind < 20)
        begin
            scan_words.push_back(8'($urandom_range(0, 255)));
        end
        else if (kind < 50)
        begin
            mod = ($urandom_range(0, 1) == 0) ? {1'b0, K_LSHIFT} : {1'b0, K_RSHIFT};
            if ($urandom_range(0, 1) == 0)
            begin
                scan_words.push_back(mod);
            end
            scan_words.push_back(k);
            if ($urandom_range(0, 3) != 0)
            begin
                scan_words.push_back(k | 8'h80);
            end
            if ($urandom_range(0, 3) != 0)
            begin
                scan_words.push_back(mod | 8'h80);
            end
        end
        else if (kind < 62)
        begin
            scan_words.push_back(CAPS_KEY);
            if ($urandom_range(0, 1) == 0)
            begin
                scan_words.push_back(CAPS_KEY | 8'h80);
            end
        end
        else if (kind < 80)
        begin
            case ($urandom_range(0, 3))
                0: e = {1'b0, K_CTRL};
                1: e = {1'b0, K_ALT};
                2: e = CAPS_KEY;
                default: e = 8'($urandom_range(0, 127));
            endcase
            scan_words.push_back(PREFIX_BYTE);
            scan_words.push_back(e);
            scan_words.push_back(k);
            scan_words.push_back(k | 8'h80);
            if ($urandom_range(0, 3) != 0)
            begin
                scan_words.push_back(PREFIX_BYTE);
                scan_words.push_back(e | 8'h80);
            end
        end
        else if (kind < 90)
        begin
            mod = ($urandom_range(0, 1) == 0) ? {1'b0, K_CTRL} : {1'b0, K_ALT};
            scan_words.push_back(mod);
            scan_words.push_back(k);
            scan_words.push_back(k | 8'h80);
            scan_words.push_back(mod | 8'h80);
        end
        else
        begin
            scan_words.push_back(PREFIX_BYTE);
            if ($urandom_range(0, 1) == 0)
            begin
                scan_words.push_back(PREFIX_BYTE);
            end
            scan_words.push_back(8'($urandom_range(0, 255)));
        end
    endtask

    task automatic check_word(input result_t want);
        if (char_valid !== want.char_valid)
            $error("char_valid expected %0h actual %0h", want.char_valid, char_valid);
        if (char_code !== want.char_code)
            $error("char_code expected %0h actual %0h", want.char_code, char_code);
        if (led_update !== want.led_update)
            $error("led_update expected %0h actual %0h", want.led_update, led_update);
        if (led_bits !== want.led_bits)
            $error("led_bits expected %0h actual %0h", want.led_bits, led_bits);
        if (shift_on !== want.shift_on)
            $error("shift_on expected %0h actual %0h", want.shift_on, shift_on);
        if (ctrl_on !== want.ctrl_on)
            $error("ctrl_on expected %0h actual %0h", want.ctrl_on, ctrl_on);
        if (alt_on !== want.alt_on)
            $error("alt_on expected %0h actual %0h", want.alt_on, alt_on);
        if (result_t'({char_valid, char_code, led_update, led_bits,
                       shift_on, ctrl_on, alt_on}) !== want)
        begin
            errors++;
        end
    endtask

    always @(posedge clk)
    begin
        int      phase;
        int      send_idle;
        int      recv_idle;
        bit      moved;
        result_t want;
        if (rst_n)
        begin
            moved = 1'b0;
            if (result_valid && !result_stall)
            begin
                moved = 1'b1;
                if (expected_words.size() == 0)
                begin
                    $error("result word with nothing expected");
                    errors++;
                end
                else
                begin
                    check_word(expected_words.pop_front());
                end
            end
            if (scan_valid && !scan_stall)
            begin
                moved = 1'b1;
                want = decode_word(scan_byte);
                if (words_sent < pinned.size() && pinned[words_sent])
                begin
                    want = pinned_want[words_sent];
                end
                expected_words.push_back(want);
                words_sent++;
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;

            phase = (words_sent * 3) / scan_words.size();
            send_idle = (phase == 0) ? 33 : (phase == 1) ? 54 : 0;
            recv_idle = (phase == 0) ? 54 : (phase == 1) ? 33 : 0;

            if (!scan_valid || !scan_stall)
            begin
                if (words_sent < scan_words.size() && $urandom_range(0, 99) >= send_idle)
                begin
                    scan_valid <= 1'b1;
                    scan_byte  <= scan_words[words_sent];
                end
                else
                begin
                    scan_valid <= 1'b0;
                end
            end
            result_stall <= ($urandom_range(0, 99) < recv_idle);
        end
    end

    initial
    begin
        // '~' marks a key with no character
        plain_keys = {"~~1234567890-=\010\t", "qwertyuiop[]\n~as", "dfghjkl;'~~\\zxcv",
                      "bnm,./~*~ ~~~~~~", "~~~~~~~789-456+1", "230."};
        shift_keys = {"~~!@#$%^&*()_+\010\t", "QWERTYUIOP{}\n~AS", "DFGHJKL:\"~~|ZXCV",
                      "BNM<>?~*~ ~~~~~~", "~~~~~~~789-456+1", "230."};
        held_keys     = '0;
        held_ext_keys = '0;
        prefix_seen   = 1'b0;
        caps_lock     = 1'b0;
        words_sent    = 0;
        idle_cycles   = 0;
        errors        = 0;

        add_row(8'h00, 1'b1, {1'b0, 7'h00, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0});
        add_row(8'hff, 1'b1, {1'b0, 7'h00, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0});
        add_row(8'h80, 1'b1, {1'b0, 7'h00, 1'b0, 3'd0, 1'b0, 1'b0, 1'b0});
        add_row(8'h1e, 1'b0, '0);
        add_row(CAPS_KEY, 1'b1, {1'b0, 7'h00, 1'b1, 3'd4, 1'b0, 1'b0, 1'b0});
        add_row(8'h1e, 1'b0, '0);
        add_row({1'b0, K_LSHIFT}, 1'b0, '0);
        add_row(8'h1e, 1'b0, '0);
        add_row(8'h02, 1'b0, '0);
        add_row({1'b1, K_LSHIFT}, 1'b0, '0);
        add_row(CAPS_KEY | 8'h80, 1'b0, '0);
        add_row(CAPS_KEY, 1'b1, {1'b0, 7'h00, 1'b1, 3'd0, 1'b0, 1'b0, 1'b0});
        add_row(PREFIX_BYTE, 1'b0, '0);
        add_row(PREFIX_BYTE, 1'b0, '0);
        add_row({1'b0, K_CTRL}, 1'b0, '0);
        add_row(PREFIX_BYTE, 1'b0, '0);
        add_row(CAPS_KEY, 1'b0, '0);
        add_row(PREFIX_BYTE, 1'b0, '0);
        add_row(CAPS_KEY | 8'h80, 1'b0, '0);
        add_row({1'b0, K_ALT}, 1'b0, '0);
        add_row(8'h10, 1'b0, '0);
        add_row(PREFIX_BYTE, 1'b0, '0);
        add_row({1'b1, K_CTRL}, 1'b0, '0);
        add_row({1'b1, K_ALT}, 1'b0, '0);
        add_row(8'he1, 1'b0, '0);
        add_row(8'hfa, 1'b0, '0);
        add_row(8'h7f, 1'b0, '0);

        while (scan_words.size() < pinned.size() + RANDOM_WORDS)
        begin
            add_random_sequence();
        end

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        while ((words_sent < scan_words.size() || expected_words.size() != 0)
               && idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
        end
        if (idle_cycles < STALL_LIMIT)
        begin
            repeat (DRAIN_CYCLES) @(posedge clk);
        end

        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("tb: failure");
        end
        else if (errors == 0)
        begin
            $display("tb: success");
        end
        else
        begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule

`default_nettype wire
